@@ hw/rtl/srrl_pkg.sv @@
// Shared types, codes and helpers of the system error recovery rate limiter.
`default_nettype none

package srrl_pkg;

    // History ring depth default
    localparam int HISTORY_DEPTH_DEF = 4;

    // Register reset values
    localparam logic [31:0] MIN_INTERVAL_RST   = 32'd300000;
    localparam logic [31:0] MONITOR_PERIOD_RST = 32'd3600000;

    // Register indexes (byte address bit 2)
    localparam logic REG_MIN_INTERVAL   = 1'b0;
    localparam logic REG_MONITOR_PERIOD = 1'b1;

    // Item modes
    localparam logic MODE_ERROR   = 1'b0;
    localparam logic MODE_RESTART = 1'b1;

    // Severity thresholds
    localparam logic [2:0] LVL_LOG_ONLY = 3'd1;
    localparam logic [2:0] LVL_ACTION   = 3'd5;
    localparam logic [2:0] LVL_FULL     = 3'd7;

    // Verdict codes
    localparam logic [3:0] V_LOGGED    = 4'd0;
    localparam logic [3:0] V_IGN_RESET = 4'd1;
    localparam logic [3:0] V_IGN_SAME  = 4'd2;
    localparam logic [3:0] V_NO_ACTION = 4'd3;
    localparam logic [3:0] V_FULL      = 4'd4;
    localparam logic [3:0] V_TOO_SOON  = 4'd5;
    localparam logic [3:0] V_TOO_MANY  = 4'd6;
    localparam logic [3:0] V_RECOVERY  = 4'd7;
    localparam logic [3:0] V_RESTART   = 4'd8;

    // Input transfer payload
    typedef struct packed {
        logic        mode;
        logic [31:0] now_ticks;
        logic [3:0]  subsystem;
        logic [2:0]  code_level;
        logic [2:0]  escalated_level;
        logic        error_safe;
        logic        manager_failed;
        logic        recovery_running;
        logic [3:0]  recovering_subsystem;
    } in_item_t;

    // Result transfer payload
    typedef struct packed {
        logic [3:0]  verdict;
        logic        full_reset;
        logic        service_recovery;
        logic [31:0] stamp_used;
    } out_item_t;

    // State update request from the classifier
    typedef struct packed {
        logic        restart;
        logic        recover;
        logic        clear_hist;
        logic [31:0] stamp;
    } upd_t;

    // now within [start, start + len], modulo 2^32 with half-range test
    function automatic logic in_window(logic [31:0] now, logic [31:0] start,
                                       logic [31:0] len);
        logic [31:0] win_end;
        logic [31:0] d_lo;
        logic [31:0] d_hi;
        begin
            win_end   = start + len;
            d_lo      = now - start;
            d_hi      = win_end - now;
            in_window = !d_lo[31] && !d_hi[31];
        end
    endfunction

endpackage

`default_nettype wire

@@ hw/rtl/srrl_classify.sv @@
// Classifier: one item against the history state, gives result and state update.
`default_nettype none

module srrl_classify #(
    parameter int HISTORY_DEPTH = srrl_pkg::HISTORY_DEPTH_DEF
) (
    input  srrl_pkg::in_item_t  item_i,
    input  logic [31:0]         min_interval_i,
    input  logic [31:0]         monitor_period_i,
    input  logic [31:0]         stamps_i [HISTORY_DEPTH],
    input  logic [31:0]         last_stamp_i,
    output srrl_pkg::out_item_t result_o,
    output srrl_pkg::upd_t      upd_o
);
    import srrl_pkg::*;

    logic [31:0] now_fix;
    logic        have_last;
    logic        too_soon;
    logic        all_in;
    logic [3:0]  verdict;

    // Zero time is reserved for an empty stamp
    assign now_fix   = (item_i.now_ticks == 32'd0) ? 32'd1 : item_i.now_ticks;
    assign have_last = (last_stamp_i != 32'd0);

    // Minimum interval since the last recovery
    assign too_soon = (min_interval_i != 32'd0) &&
                      in_window(now_fix, last_stamp_i, min_interval_i);

    // Every history entry filled and inside the monitor period
    always_comb begin
        all_in = 1'b1;
        for (int i = 0; i < HISTORY_DEPTH; i++) begin
            if (stamps_i[i] == 32'd0 || !in_window(now_fix, stamps_i[i], monitor_period_i)) begin
                all_in = 1'b0;
            end
        end
    end

    // Ordered checks
    always_comb begin
        verdict = V_RECOVERY;
        if (item_i.mode == MODE_RESTART) begin
            verdict = V_RESTART;
        end else if (item_i.code_level == LVL_LOG_ONLY) begin
            verdict = V_LOGGED;
        end else if (item_i.error_safe || item_i.manager_failed) begin
            verdict = V_IGN_RESET;
        end else if (item_i.recovery_running &&
                     item_i.recovering_subsystem == item_i.subsystem) begin
            verdict = V_IGN_SAME;
        end else if (item_i.escalated_level < LVL_ACTION) begin
            verdict = V_NO_ACTION;
        end else if (item_i.escalated_level >= LVL_FULL || item_i.recovery_running) begin
            verdict = V_FULL;
        end else if (have_last && too_soon) begin
            verdict = V_TOO_SOON;
        end else if (have_last && monitor_period_i != 32'd0 && all_in) begin
            verdict = V_TOO_MANY;
        end
    end

    // Result fields
    always_comb begin
        result_o.verdict          = verdict;
        result_o.full_reset       = (verdict == V_FULL) || (verdict == V_TOO_SOON) ||
                                    (verdict == V_TOO_MANY);
        result_o.service_recovery = (verdict == V_RECOVERY);
        result_o.stamp_used       = (verdict == V_RECOVERY) ? now_fix : 32'd0;
    end

    // State update; first recovery after restart wipes the history
    always_comb begin
        upd_o.restart    = (verdict == V_RESTART);
        upd_o.recover    = (verdict == V_RECOVERY);
        upd_o.clear_hist = (verdict == V_RECOVERY) && !have_last;
        upd_o.stamp      = now_fix;
    end

endmodule

`default_nettype wire

@@ hw/rtl/syserr_recovery_rate_limiter.sv @@
// Top level of the system error recovery rate limiter: pipeline, state and registers.
//
//  Channel  Ports                 Direction  Payload
//  -------  --------------------  ---------  ------------------------------
//  input    s_valid/s_ready       in         s_data  (srrl_pkg::in_item_t)
//  result   m_valid/m_ready       out        m_data  (srrl_pkg::out_item_t)
//  config   psel/penable/...      APB        two 32-bit registers, 0x0, 0x4
//
// One item per cycle sustained while the result side takes results; an item passes
// the input register, then the classifier, then the result register.
// History, slot and last stamp are updated as an item moves into the result
// register, so the next item already sees them.
// Synchronous active-low reset clears state and loads register defaults.
// A stalled result holds; the input register still takes a transfer while
// it is empty.
`default_nettype none

module syserr_recovery_rate_limiter #(
    parameter int HISTORY_DEPTH = srrl_pkg::HISTORY_DEPTH_DEF
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  srrl_pkg::in_item_t  s_data,
    output logic                m_valid,
    input  logic                m_ready,
    output srrl_pkg::out_item_t m_data,
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [2:0]          paddr,
    input  logic [31:0]         pwdata,
    output logic [31:0]         prdata,
    output logic                pready
);
    import srrl_pkg::*;

    localparam int SLOT_W = (HISTORY_DEPTH > 1) ? $clog2(HISTORY_DEPTH) : 1;

    logic              in_valid_reg;
    in_item_t          in_item_reg;
    logic              out_valid_reg;
    out_item_t         out_item_reg;
    logic [31:0]       min_interval_reg;
    logic [31:0]       monitor_period_reg;
    logic [31:0]       stamps_reg [HISTORY_DEPTH];
    logic [31:0]       stamps_next [HISTORY_DEPTH];
    logic [SLOT_W-1:0] slot_reg;
    logic [SLOT_W-1:0] slot_next;
    logic [31:0]       last_stamp_reg;
    logic              advance;
    logic              cfg_write;
    out_item_t         result;
    upd_t              upd;

    // Handshake
    assign advance = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || advance;
    assign m_valid = out_valid_reg;
    assign m_data  = out_item_reg;

    // Input register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
        if (s_valid && s_ready) begin
            in_item_reg <= s_data;
        end
    end

    srrl_classify #(
        .HISTORY_DEPTH(HISTORY_DEPTH)
    ) u_classify (
        .item_i           (in_item_reg),
        .min_interval_i   (min_interval_reg),
        .monitor_period_i (monitor_period_reg),
        .stamps_i         (stamps_reg),
        .last_stamp_i     (last_stamp_reg),
        .result_o         (result),
        .upd_o            (upd)
    );

    // Result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            out_valid_reg <= 1'b1;
        end else if (m_ready) begin
            out_valid_reg <= 1'b0;
        end
        if (advance) begin
            out_item_reg <= result;
        end
    end

    // History ring next values
    always_comb begin
        for (int i = 0; i < HISTORY_DEPTH; i++) begin
            stamps_next[i] = stamps_reg[i];
            if (upd.clear_hist) begin
                stamps_next[i] = 32'd0;
            end
            if (upd.recover && slot_reg == SLOT_W'(i)) begin
                stamps_next[i] = upd.stamp;
            end
        end
        slot_next = (slot_reg == SLOT_W'(HISTORY_DEPTH - 1)) ? '0 : slot_reg + SLOT_W'(1);
    end

    // Recovery state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < HISTORY_DEPTH; i++) begin
                stamps_reg[i] <= 32'd0;
            end
            slot_reg       <= '0;
            last_stamp_reg <= 32'd0;
        end else if (advance) begin
            stamps_reg <= stamps_next;
            if (upd.recover) begin
                slot_reg       <= slot_next;
                last_stamp_reg <= upd.stamp;
            end else if (upd.restart) begin
                last_stamp_reg <= 32'd0;
            end
        end
    end

    // Configuration registers
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            min_interval_reg   <= MIN_INTERVAL_RST;
            monitor_period_reg <= MONITOR_PERIOD_RST;
        end else if (cfg_write) begin
            unique case (paddr[2])
                REG_MIN_INTERVAL:   min_interval_reg   <= pwdata;
                REG_MONITOR_PERIOD: monitor_period_reg <= pwdata;
                default:            min_interval_reg   <= min_interval_reg;
            endcase
        end
    end

    // Register read
    always_comb begin
        unique case (paddr[2])
            REG_MIN_INTERVAL:   prdata = min_interval_reg;
            REG_MONITOR_PERIOD: prdata = monitor_period_reg;
            default:            prdata = 32'd0;
        endcase
    end

endmodule

`default_nettype wire

@@ hw/rtl/srrl_checker.sv @@
// Port-level checker for the rate limiter, bound to the top level.
`default_nettype none

module srrl_checker (
    input wire                 aclk,
    input wire                 aresetn,
    input wire                 m_valid,
    input wire                 m_ready,
    input srrl_pkg::out_item_t m_data,
    input wire                 pready
);
    import srrl_pkg::*;

    // A stalled result holds
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("result changed while stalled");

    // Full reset flag follows the verdict
    a_full: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> m_data.full_reset == ((m_data.verdict == V_FULL) ||
                    (m_data.verdict == V_TOO_SOON) || (m_data.verdict == V_TOO_MANY)))
        else $error("full_reset does not match verdict");

    // A recovery carries a non-zero stamp, anything else carries none
    a_stamp: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_data.service_recovery == (m_data.verdict == V_RECOVERY)) &&
                    ((m_data.stamp_used != 32'd0) == m_data.service_recovery))
        else $error("stamp or service flag inconsistent");

    // Verdict within its code range
    a_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> m_data.verdict <= V_RESTART)
        else $error("verdict code out of range");

    // Register port never waits
    a_pready: assert property (@(posedge aclk) disable iff (!aresetn)
        pready)
        else $error("pready low");

endmodule

bind syserr_recovery_rate_limiter srrl_checker u_srrl_checker (
    .aclk    (aclk),
    .aresetn (aresetn),
    .m_valid (m_valid),
    .m_ready (m_ready),
    .m_data  (m_data),
    .pready  (pready)
);

`default_nettype wire

@@ tb/srrl_verdict_check.sv @@
// Result checker for the recovery rate limiter: watches transfers, predicts verdicts, compares.
`timescale 1ns / 100ps

module srrl_verdict_check (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    input  logic                s_ready,
    input  srrl_pkg::in_item_t  s_data,
    input  logic                m_valid,
    input  logic                m_ready,
    input  srrl_pkg::out_item_t m_data,
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [2:0]          paddr,
    input  logic [31:0]         pwdata,
    input  logic [31:0]         prdata,
    input  logic                pready,
    output int unsigned         mismatches,
    output int unsigned         pending,
    output int unsigned         results_checked,
    output logic [8:0]          verdicts_seen
);
    import srrl_pkg::*;

    localparam int          RING_DEPTH = HISTORY_DEPTH_DEF;
    localparam logic [31:0] HALF_RANGE = 32'h8000_0000;

    // Mirrored registers and recovery history
    logic [31:0] gap_min;
    logic [31:0] watch_span;
    logic [31:0] ring [RING_DEPTH];
    int unsigned ring_slot;
    logic [31:0] last_stamp;

    // Verdicts still owed by the block, oldest first
    out_item_t   due_q [$];
    int unsigned fail_total    = 0;
    int unsigned checked_total = 0;
    logic [8:0]  seen          = '0;

    assign mismatches      = fail_total;
    assign results_checked = checked_total;
    assign verdicts_seen   = seen;

    task automatic flag_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
        $display("%0t ns: mismatch on %s, got 0x%0h, expected 0x%0h",
                 $time, what, got, want);
        fail_total++;
    endtask

    // t lies in [start, start + len], all modulo 2^32
    function automatic logic tick_in_span(input logic [31:0] t, input logic [31:0] start,
                                          input logic [31:0] len);
        logic [31:0] ahead;
        logic [31:0] left;
        ahead = t - start;
        left  = start + len - t;
        return (ahead < HALF_RANGE) && (left < HALF_RANGE);
    endfunction

    // Classify one event and update the history as the block would
    function automatic out_item_t judge_event(input in_item_t it);
        out_item_t   r;
        logic [31:0] t;
        logic        crowded;
        int          k;
        r = '0;
        if (it.mode == MODE_RESTART) begin
            last_stamp = '0;
            r.verdict  = V_RESTART;
            return r;
        end
        // a zero stamp would read as an empty slot
        t = (it.now_ticks == '0) ? 32'd1 : it.now_ticks;
        crowded = (watch_span != '0);
        for (k = 0; k < RING_DEPTH; k++) begin
            if (ring[k] == '0 || !tick_in_span(t, ring[k], watch_span))
                crowded = 1'b0;
        end
        if (it.code_level == LVL_LOG_ONLY) begin
            r.verdict = V_LOGGED;
        end else if (it.error_safe || it.manager_failed) begin
            r.verdict = V_IGN_RESET;
        end else if (it.recovery_running && it.recovering_subsystem == it.subsystem) begin
            r.verdict = V_IGN_SAME;
        end else if (it.escalated_level < LVL_ACTION) begin
            r.verdict = V_NO_ACTION;
        end else if (it.escalated_level >= LVL_FULL || it.recovery_running) begin
            r.verdict = V_FULL;
        end else if (last_stamp != '0 && gap_min != '0
                     && tick_in_span(t, last_stamp, gap_min)) begin
            r.verdict = V_TOO_SOON;
        end else if (last_stamp != '0 && crowded) begin
            r.verdict = V_TOO_MANY;
        end else begin
            // first recovery since a restart starts a fresh history
            if (last_stamp == '0) begin
                for (k = 0; k < RING_DEPTH; k++)
                    ring[k] = '0;
            end
            ring[ring_slot] = t;
            ring_slot       = (ring_slot + 1 >= RING_DEPTH) ? 0 : ring_slot + 1;
            last_stamp      = t;
            r.verdict       = V_RECOVERY;
            r.stamp_used    = t;
        end
        r.full_reset = (r.verdict == V_FULL) || (r.verdict == V_TOO_SOON)
                       || (r.verdict == V_TOO_MANY);
        r.service_recovery = (r.verdict == V_RECOVERY);
        return r;
    endfunction

    // Sample all three ports at the clock edge
    always @(posedge aclk) begin
        out_item_t   want;
        logic [31:0] reg_val;
        int          k;
        if (!aresetn) begin
            gap_min    = MIN_INTERVAL_RST;
            watch_span = MONITOR_PERIOD_RST;
            for (k = 0; k < RING_DEPTH; k++)
                ring[k] = '0;
            ring_slot  = 0;
            last_stamp = '0;
            due_q.delete();
        end else begin
            // result transfer against the oldest prediction
            if (m_valid && m_ready) begin
                if (due_q.size() == 0) begin
                    flag_mismatch("unexpected result verdict", 32'(m_data.verdict), '0);
                end else begin
                    want = due_q.pop_front();
                    checked_total++;
                    seen[want.verdict] = 1'b1;
                    if (m_data.verdict !== want.verdict)
                        flag_mismatch("verdict", 32'(m_data.verdict), 32'(want.verdict));
                    if (m_data.full_reset !== want.full_reset)
                        flag_mismatch("full_reset", 32'(m_data.full_reset),
                                      32'(want.full_reset));
                    if (m_data.service_recovery !== want.service_recovery)
                        flag_mismatch("service_recovery", 32'(m_data.service_recovery),
                                      32'(want.service_recovery));
                    if (m_data.stamp_used !== want.stamp_used)
                        flag_mismatch("stamp_used", m_data.stamp_used, want.stamp_used);
                end
            end
            // input transfer
            if (s_valid && s_ready)
                due_q.push_back(judge_event(s_data));
            // register access
            if (psel && penable && pready) begin
                reg_val = (paddr[2] == REG_MIN_INTERVAL) ? gap_min : watch_span;
                if (pwrite) begin
                    if (paddr[2] == REG_MIN_INTERVAL)
                        gap_min = pwdata;
                    else
                        watch_span = pwdata;
                end else if (prdata !== reg_val) begin
                    flag_mismatch("register read", prdata, reg_val);
                end
            end
        end
        pending <= due_q.size();
    end

endmodule

@@ tb/syserr_recovery_rate_limiter_test.sv @@
// Top of the recovery rate limiter testbench: clock, reset, stimulus and final verdict.
`timescale 1ns / 100ps

module syserr_recovery_rate_limiter_test;
    import srrl_pkg::*;

    localparam int CLK_PERIOD   = 12;
    localparam int RESET_CYCLES = 4;
    localparam int MAX_GAP      = 12;
    localparam int IDLE_LIMIT   = 2000;
    localparam int TAIL_CYCLES  = 8;
    localparam int PHASE_ITEMS  = 190;

    logic        aclk    = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_valid = 1'b0;
    logic        s_ready;
    in_item_t    s_data  = '0;
    logic        m_valid;
    logic        m_ready = 1'b0;
    out_item_t   m_data;
    logic        psel    = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite  = 1'b0;
    logic [2:0]  paddr   = '0;
    logic [31:0] pwdata  = '0;
    logic [31:0] prdata;
    logic        pready;

    int unsigned mismatches;
    int unsigned pending;
    int unsigned results_checked;
    logic [8:0]  verdicts_seen;

    // Stimulus-side view of time and of the limits in force
    logic [31:0] tick_now      = '0;
    logic [31:0] cur_gap_min   = MIN_INTERVAL_RST;
    logic [31:0] cur_span      = MONITOR_PERIOD_RST;
    bit          send_steady   = 1'b0;
    int unsigned items_sent    = 0;
    int unsigned settings_used = 1;
    int unsigned quiet_cycles  = 0;

    syserr_recovery_rate_limiter u_dut (.*);

    srrl_verdict_check u_check (.*);

    always #(CLK_PERIOD / 2) aclk = ~aclk;

    // Watchdog: stop when no transfer happens for too long
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready) || (psel && penable)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= IDLE_LIMIT) begin
            $display("Timeout after %0d cycles without a transfer", quiet_cycles);
            $display("CHECK FAILED");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // Result side: random stalls with occasional stretches of none
    initial begin
        int unsigned stall;
        bit          steady;
        steady = 1'b0;
        @(posedge aclk);
        forever begin
            if ($urandom_range(50, 0) == 0)
                steady = !steady;
            stall = steady ? 0 : $urandom_range(MAX_GAP, 0);
            if (stall != 0) begin
                m_ready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
            m_ready <= 1'b1;
            do @(posedge aclk); while (!(m_valid && m_ready));
        end
    end

    function automatic in_item_t error_item(input logic [31:0] now, input logic [3:0] sub,
                                            input logic [2:0] code, input logic [2:0] esc,
                                            input logic safe, input logic failed,
                                            input logic run, input logic [3:0] rsub);
        in_item_t it;
        it.mode                 = MODE_ERROR;
        it.now_ticks            = now;
        it.subsystem            = sub;
        it.code_level           = code;
        it.escalated_level      = esc;
        it.error_safe           = safe;
        it.manager_failed       = failed;
        it.recovery_running     = run;
        it.recovering_subsystem = rsub;
        return it;
    endfunction

    function automatic in_item_t random_item();
        in_item_t it;
        it.mode                 = ($urandom_range(3, 0) == 0) ? MODE_RESTART : MODE_ERROR;
        it.now_ticks            = $urandom;
        it.subsystem            = 4'($urandom_range(15, 0));
        it.code_level           = 3'($urandom_range(7, 0));
        it.escalated_level      = 3'($urandom_range(7, 0));
        it.error_safe           = 1'($urandom_range(1, 0));
        it.manager_failed       = 1'($urandom_range(1, 0));
        it.recovery_running     = 1'($urandom_range(1, 0));
        it.recovering_subsystem = 4'($urandom_range(15, 0));
        return it;
    endfunction

    // Move time on by a step sized against the current limits
    function automatic void advance_clock();
        logic [31:0] delta;
        case ($urandom_range(7, 0))
            0: delta = $urandom_range(cur_gap_min, 0);
            1: delta = cur_gap_min;
            2: delta = cur_gap_min + 32'd1;
            3, 4, 5: delta = cur_gap_min + 32'd1 + $urandom_range(cur_span >> 2, 0);
            6: delta = cur_span + $urandom_range(2, 0);
            default: delta = $urandom;
        endcase
        tick_now = tick_now + delta;
    endfunction

    // One input transfer after a random gap
    task automatic push_item(input in_item_t it);
        int unsigned gap;
        if ($urandom_range(60, 0) == 0)
            send_steady = !send_steady;
        gap = send_steady ? 0 : $urandom_range(MAX_GAP, 0);
        if (gap != 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= it;
        do @(posedge aclk); while (!s_ready);
        items_sent++;
    endtask

    // Stop sending and wait until every predicted result has come back
    task automatic drain_results();
        s_valid <= 1'b0;
        do @(posedge aclk); while (pending != 0);
    endtask

    task automatic reg_access(input logic wr, input logic [2:0] addr,
                              input logic [31:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= wr;
        paddr   <= addr;
        pwdata  <= data;
        @(posedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge aclk);
    endtask

    // New limits only once the block has gone idle; read both back
    task automatic set_limits(input logic [31:0] gap, input logic [31:0] span);
        drain_results();
        reg_access(1'b1, {REG_MIN_INTERVAL, 2'b00}, gap);
        reg_access(1'b1, {REG_MONITOR_PERIOD, 2'b00}, span);
        reg_access(1'b0, {REG_MIN_INTERVAL, 2'b00}, '0);
        reg_access(1'b0, {REG_MONITOR_PERIOD, 2'b00}, '0);
        cur_gap_min = gap;
        cur_span    = span;
        settings_used++;
    endtask

    // Hand-picked items under the reset limits (300000 / 3600000)
    task automatic directed_items();
        in_item_t it;
        // priority order of the early checks
        push_item(error_item(32'h1234, 4'd3, LVL_LOG_ONLY, LVL_FULL, 1'b1, 1'b1, 1'b1, 4'd3));
        push_item(error_item(32'h1234, 4'd3, 3'd0, 3'd6, 1'b1, 1'b0, 1'b0, 4'd0));
        push_item(error_item(32'h1234, 4'd3, 3'd2, 3'd6, 1'b0, 1'b1, 1'b0, 4'd0));
        push_item(error_item(32'h1234, 4'd9, 3'd4, 3'd6, 1'b0, 1'b0, 1'b1, 4'd9));
        push_item(error_item(32'h1234, 4'd9, 3'd4, 3'd4, 1'b0, 1'b0, 1'b0, 4'd0));
        push_item(error_item(32'h1234, 4'd9, 3'd7, 3'd0, 1'b0, 1'b0, 1'b0, 4'd0));
        push_item(error_item(32'h1234, 4'd9, 3'd7, LVL_FULL, 1'b0, 1'b0, 1'b0, 4'd0));
        // recovery already running on another subsystem
        push_item(error_item(32'h1234, 4'd5, 3'd6, LVL_ACTION, 1'b0, 1'b0, 1'b1, 4'd2));
        // first recovery at tick zero is stamped as one
        push_item(error_item(32'd0, 4'd1, 3'd6, LVL_ACTION, 1'b0, 1'b0, 1'b0, 4'd0));
        // inside the minimum interval, then exactly on and just past its end
        push_item(error_item(32'd100, 4'd1, 3'd6, LVL_ACTION, 1'b0, 1'b0, 1'b0, 4'd0));
        push_item(error_item(32'd300001, 4'd1, 3'd6, 3'd6, 1'b0, 1'b0, 1'b0, 4'd0));
        push_item(error_item(32'd300002, 4'd1, 3'd6, 3'd6, 1'b0, 1'b0, 1'b0, 4'd0));
        push_item(error_item(32'd700000, 4'd2, 3'd5, 3'd6, 1'b0, 1'b0, 1'b0, 4'd0));
        push_item(error_item(32'd1100000, 4'd2, 3'd5, 3'd6, 1'b0, 1'b0, 1'b0, 4'd0));
        // too soon takes precedence over too many
        push_item(error_item(32'd1100001, 4'd2, 3'd5, 3'd6, 1'b0, 1'b0, 1'b0, 4'd0));
        push_item(error_item(32'd1500000, 4'd2, 3'd5, 3'd6, 1'b0, 1'b0, 1'b0, 4'd0));
        // restart with every other field at its maximum; history survives it
        it = error_item(32'hFFFF_FFFF, 4'hF, 3'd7, 3'd7, 1'b1, 1'b1, 1'b1, 4'hF);
        it.mode = MODE_RESTART;
        push_item(it);
        // first recovery after restart clears history, then fill and wrap the ring
        push_item(error_item(32'd1500001, 4'd4, 3'd0, 3'd6, 1'b0, 1'b0, 1'b0, 4'd0));
        push_item(error_item(32'd1900000, 4'd4, 3'd0, 3'd6, 1'b0, 1'b0, 1'b0, 4'd0));
        push_item(error_item(32'd2300000, 4'd4, 3'd0, 3'd6, 1'b0, 1'b0, 1'b0, 4'd0));
        push_item(error_item(32'd2700000, 4'd4, 3'd0, 3'd6, 1'b0, 1'b0, 1'b0, 4'd0));
        push_item(error_item(32'd5100002, 4'd4, 3'd0, 3'd6, 1'b0, 1'b0, 1'b0, 4'd0));
        // top of the tick range, then a too-soon across the wrap
        push_item(error_item(32'hFFFF_FFFF, 4'hF, 3'd7, 3'd6, 1'b0, 1'b0, 1'b0, 4'hF));
        push_item(error_item(32'd299999, 4'hF, 3'd7, 3'd6, 1'b0, 1'b0, 1'b0, 4'hE));
    endtask

    // Mostly well-formed recovery candidates on a moving clock, some noise
    task automatic run_random(input int unsigned count);
        in_item_t    it;
        int unsigned pick;
        logic [3:0]  sub;
        logic [2:0]  code;
        logic [2:0]  esc;
        repeat (count) begin
            pick = $urandom_range(99, 0);
            if (pick < 70) begin
                advance_clock();
                if ($urandom_range(49, 0) == 0)
                    tick_now = '0;
                sub  = 4'($urandom_range(15, 0));
                code = 3'($urandom_range(7, 0));
                if (code == LVL_LOG_ONLY)
                    code = 3'd0;
                esc  = ($urandom_range(9, 0) == 0) ? LVL_FULL : 3'($urandom_range(6, 5));
                if ($urandom_range(9, 0) == 0)
                    it = error_item(tick_now, sub, code, esc, 1'b0, 1'b0, 1'b1,
                                    sub ^ 4'($urandom_range(15, 1)));
                else
                    it = error_item(tick_now, sub, code, esc, 1'b0, 1'b0, 1'b0,
                                    4'($urandom_range(15, 0)));
            end else begin
                it = random_item();
                if (pick < 78) begin
                    it.mode = MODE_RESTART;
                    if (pick[0])
                        it.now_ticks = tick_now;
                end
            end
            push_item(it);
        end
    endtask

    initial begin
        repeat (RESET_CYCLES) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        // reset values of both registers
        reg_access(1'b0, {REG_MIN_INTERVAL, 2'b00}, '0);
        reg_access(1'b0, {REG_MONITOR_PERIOD, 2'b00}, '0);
        directed_items();

        set_limits(32'd10, 32'd100);
        run_random(PHASE_ITEMS);
        set_limits('0, '0);
        run_random(PHASE_ITEMS);
        set_limits(32'hFFFF_FFFF, 32'hFFFF_FFFF);
        run_random(PHASE_ITEMS);
        set_limits('0, 32'd50);
        run_random(PHASE_ITEMS);
        set_limits(32'd1, 32'd1);
        run_random(PHASE_ITEMS);
        set_limits($urandom_range(5000, 1), $urandom_range(60000, 3000));
        run_random(PHASE_ITEMS);
        set_limits(MIN_INTERVAL_RST, MONITOR_PERIOD_RST);
        run_random(PHASE_ITEMS);

        drain_results();
        repeat (TAIL_CYCLES) @(posedge aclk);
        $display("Ran %0d items under %0d limit settings; %0d results compared",
                 items_sent, settings_used, results_checked);
        $display("Verdict kinds produced: %0d of 9 (mask 0x%03h)",
                 $countones(verdicts_seen), verdicts_seen);
        if (mismatches == 0 && pending == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
